@@ sv/mt_pkg.sv @@
// shared types, constants and helper functions of the mersenne twister generator
// no dependencies
`default_nettype none

package mt_pkg;

  // fixed geometry of the state store
  localparam int STATE_DEPTH = 624;
  localparam int TAP_OFFSET  = 397;
  localparam int IDX_W       = 10;
  localparam int KEY_MAX_DEF = 16;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // word index marks
  localparam logic [IDX_W-1:0] IDX_USED  = IDX_W'(STATE_DEPTH);
  localparam logic [IDX_W-1:0] IDX_NEVER = IDX_W'(STATE_DEPTH + 1);
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(STATE_DEPTH - 1);
  localparam logic [IDX_W-1:0] IDX_TAP   = IDX_W'(TAP_OFFSET);

  // operation codes of a request
  localparam logic [1:0] OP_DRAW   = 2'd0;
  localparam logic [1:0] OP_RESEED = 2'd1;
  localparam logic [1:0] OP_KEY    = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  // algorithm constants
  localparam logic [31:0] SEED_DEFAULT = 32'd5489;
  localparam logic [31:0] SEED_KEY     = 32'd19650218;
  localparam logic [31:0] MUL_LIN      = 32'd1812433253;
  localparam logic [31:0] MUL_KEY1     = 32'd1664525;
  localparam logic [31:0] MUL_KEY2     = 32'd1566083941;
  localparam logic [31:0] TWIST_MATRIX = 32'h9908b0df;
  localparam logic [31:0] HIGH_BIT     = 32'h80000000;
  localparam logic [31:0] TEMPER_B     = 32'h9d2c5680;
  localparam logic [31:0] TEMPER_C     = 32'hefc60000;

  // one queued request
  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] word;
    logic        last;
  } cmd_t;

  // output tempering
  function automatic logic [31:0] temper(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  // shared mixing term p ^ (p >> 30)
  function automatic logic [31:0] mix30(input logic [31:0] p);
    return p ^ (p >> 30);
  endfunction

endpackage

`default_nettype wire

@@ sv/mt_ram.sv @@
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module mt_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ sv/mt_front.sv @@
// request intake: drops unused codes and queues requests for the engine
// depends on mt_pkg
`default_nettype none

module mt_front (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  output logic              full,
  input  wire logic [1:0]   op,
  input  wire logic [31:0]  key_word,
  input  wire logic         key_last,
  output logic              cmd_valid,
  output mt_pkg::cmd_t      cmd,
  input  wire logic         cmd_pop
);

  import mt_pkg::*;

  cmd_t              q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              store;
  logic              take;

  assign full      = (count == QCNT_W'(QDEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = q[rd_ptr];
  assign store     = push && !full && (op != OP_NONE);
  assign take      = cmd_pop && cmd_valid;

  // queue storage
  always_ff @(posedge clk) begin
    if (store) begin
      q[wr_ptr] <= '{op: op, word: key_word, last: key_last};
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (store) wr_ptr <= wr_ptr + 1'b1;
      if (take)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({store, take})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ sv/mt_back.sv @@
// request engine: seeding, key initialization, twisting and tempered draws
// depends on mt_pkg and mt_ram
`default_nettype none

module mt_back #(
  parameter int KEY_MAX = mt_pkg::KEY_MAX_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic [31:0]  seed_value,
  input  wire logic         cmd_valid,
  input  wire mt_pkg::cmd_t cmd,
  output logic              cmd_pop,
  output logic              empty,
  input  wire logic         pop,
  output logic [31:0]       random_value
);

  import mt_pkg::*;

  localparam int KEY_AW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
  localparam int KEY_CW = $clog2(KEY_MAX + 1);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_LIN0  = 4'd1;
  localparam logic [3:0] ST_LINM  = 4'd2;
  localparam logic [3:0] ST_LINW  = 4'd3;
  localparam logic [3:0] ST_TW0   = 4'd4;
  localparam logic [3:0] ST_TWCUR = 4'd5;
  localparam logic [3:0] ST_TWA   = 4'd6;
  localparam logic [3:0] ST_TWB   = 4'd7;
  localparam logic [3:0] ST_TWC   = 4'd8;
  localparam logic [3:0] ST_DRD   = 4'd9;
  localparam logic [3:0] ST_DOUT  = 4'd10;
  localparam logic [3:0] ST_KR    = 4'd11;
  localparam logic [3:0] ST_KC    = 4'd12;
  localparam logic [3:0] ST_KWRAP = 4'd13;
  localparam logic [3:0] ST_KNEXT = 4'd14;
  localparam logic [3:0] ST_KFIN  = 4'd15;

  localparam logic [1:0] MODE_DRAW   = 2'd0;
  localparam logic [1:0] MODE_RESEED = 2'd1;
  localparam logic [1:0] MODE_KEY    = 2'd2;

  logic [3:0]        st;
  logic [1:0]        mode;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  a;
  logic [IDX_W-1:0]  tap;
  logic [IDX_W-1:0]  cnt;
  logic [KEY_AW-1:0] bpos;
  logic [KEY_CW-1:0] klen;
  logic [KEY_CW-1:0] kcount;
  logic              pass2;
  logic [31:0]       p;
  logic [31:0]       cur;
  logic [31:0]       nxt;
  logic [31:0]       mulr;
  logic [31:0]       seed_lat;
  logic              out_valid;
  logic [31:0]       out_word;

  logic              s_we;
  logic [IDX_W-1:0]  s_waddr;
  logic [31:0]       s_wdata;
  logic [IDX_W-1:0]  s_raddr;
  logic [31:0]       s_rdata;
  logic              k_we;
  logic [31:0]       k_rdata;

  logic [IDX_W-1:0]  a_inc;
  logic [31:0]       twy;
  logic [31:0]       tw_val;
  logic [31:0]       lin_val;
  logic [31:0]       k_mix;
  logic [31:0]       k_val;
  logic [31:0]       mul_k;
  logic [KEY_CW-1:0] bnext;
  logic              key_room;
  logic              out_free;

  // state store and key store
  mt_ram #(.WIDTH(32), .DEPTH(STATE_DEPTH), .ADDR_W(IDX_W)) u_state (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  mt_ram #(.WIDTH(32), .DEPTH(KEY_MAX), .ADDR_W(KEY_AW)) u_key (
    .clk(clk), .we(k_we), .waddr(kcount[KEY_AW-1:0]), .wdata(cmd.word),
    .raddr(bpos), .rdata(k_rdata)
  );

  // datapath terms
  assign a_inc    = (a == IDX_LAST) ? '0 : a + 1'b1;
  assign twy      = {cur[31], nxt[30:0]};
  assign tw_val   = s_rdata ^ (twy >> 1) ^ (twy[0] ? TWIST_MATRIX : 32'd0);
  assign lin_val  = mulr + 32'(a);
  assign k_mix    = s_rdata ^ mulr;
  assign k_val    = pass2 ? (k_mix - 32'(a)) : (k_mix + k_rdata + 32'(bpos));
  assign mul_k    = (st == ST_LINM) ? MUL_LIN : (pass2 ? MUL_KEY2 : MUL_KEY1);
  assign bnext    = KEY_CW'(bpos) + 1'b1;
  assign key_room = (kcount < KEY_CW'(KEY_MAX));
  assign out_free = !out_valid || pop;

  assign empty        = !out_valid;
  assign random_value = out_word;

  // memory port control
  always_comb begin
    s_we    = 1'b0;
    s_waddr = a;
    s_wdata = 32'd0;
    s_raddr = a;
    k_we    = 1'b0;
    cmd_pop = 1'b0;
    unique case (st)
      ST_IDLE: begin
        cmd_pop = cmd_valid;
        k_we    = cmd_valid && (cmd.op == OP_KEY) && key_room;
      end
      ST_LIN0: begin
        s_we    = 1'b1;
        s_waddr = '0;
        s_wdata = seed_lat;
      end
      ST_LINW: begin
        s_we    = 1'b1;
        s_wdata = lin_val;
      end
      ST_TW0:   s_raddr = '0;
      ST_TWCUR: s_raddr = a_inc;
      ST_TWA:   s_raddr = a_inc;
      ST_TWB:   s_raddr = tap;
      ST_TWC: begin
        s_we    = 1'b1;
        s_wdata = tw_val;
      end
      ST_DRD:  s_raddr = idx;
      ST_DOUT: s_raddr = idx;
      ST_KC: begin
        s_we    = 1'b1;
        s_wdata = k_val;
      end
      ST_KWRAP: begin
        s_we    = 1'b1;
        s_waddr = '0;
        s_wdata = p;
      end
      ST_KFIN: begin
        s_we    = 1'b1;
        s_waddr = '0;
        s_wdata = HIGH_BIT;
      end
      default: s_raddr = a;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st     <= ST_IDLE;
      idx    <= IDX_NEVER;
      kcount <= '0;
    end else begin
      unique case (st)
        ST_IDLE: begin
          if (cmd_valid) begin
            priority case (cmd.op)
              OP_DRAW: begin
                mode     <= MODE_DRAW;
                seed_lat <= SEED_DEFAULT;
                if (idx == IDX_NEVER) st <= ST_LIN0;
                else if (idx == IDX_USED) st <= ST_TW0;
                else st <= ST_DRD;
              end
              OP_RESEED: begin
                mode     <= MODE_RESEED;
                seed_lat <= seed_value;
                st       <= ST_LIN0;
              end
              OP_KEY: begin
                if (cmd.last) begin
                  klen     <= key_room ? kcount + 1'b1 : kcount;
                  kcount   <= '0;
                  mode     <= MODE_KEY;
                  seed_lat <= SEED_KEY;
                  st       <= ST_LIN0;
                end else if (key_room) begin
                  kcount <= kcount + 1'b1;
                end
              end
              default: st <= ST_IDLE;
            endcase
          end
        end
        ST_LIN0: begin
          p  <= seed_lat;
          a  <= IDX_W'(1);
          st <= ST_LINM;
        end
        ST_LINM: begin
          mulr <= mix30(p) * mul_k;
          st   <= ST_LINW;
        end
        ST_LINW: begin
          if (a == IDX_LAST) begin
            idx <= IDX_USED;
            priority case (mode)
              MODE_DRAW: st <= ST_TW0;
              MODE_KEY: begin
                p     <= seed_lat;
                a     <= IDX_W'(1);
                bpos  <= '0;
                cnt   <= IDX_USED;
                pass2 <= 1'b0;
                st    <= ST_KR;
              end
              default: st <= ST_IDLE;
            endcase
          end else begin
            p  <= lin_val;
            a  <= a + 1'b1;
            st <= ST_LINM;
          end
        end
        // twist
        ST_TW0: begin
          a   <= '0;
          tap <= IDX_TAP;
          st  <= ST_TWCUR;
        end
        ST_TWCUR: begin
          cur <= s_rdata;
          st  <= ST_TWB;
        end
        ST_TWA: st <= ST_TWB;
        ST_TWB: begin
          nxt <= s_rdata;
          st  <= ST_TWC;
        end
        ST_TWC: begin
          cur <= nxt;
          if (a == IDX_LAST) begin
            idx <= '0;
            st  <= ST_DRD;
          end else begin
            a   <= a + 1'b1;
            tap <= (tap == IDX_LAST) ? '0 : tap + 1'b1;
            st  <= ST_TWA;
          end
        end
        // draw
        ST_DRD: st <= ST_DOUT;
        ST_DOUT: begin
          if (out_free) begin
            idx <= idx + 1'b1;
            st  <= ST_IDLE;
          end
        end
        // key mixing passes
        ST_KR: begin
          mulr <= mix30(p) * mul_k;
          st   <= ST_KC;
        end
        ST_KC: begin
          p   <= k_val;
          cnt <= cnt - 1'b1;
          if (!pass2) begin
            bpos <= (bnext >= klen) ? '0 : bnext[KEY_AW-1:0];
          end
          if (a == IDX_LAST) begin
            a  <= IDX_W'(1);
            st <= ST_KWRAP;
          end else begin
            a  <= a + 1'b1;
            st <= ST_KNEXT;
          end
        end
        ST_KWRAP: st <= ST_KNEXT;
        ST_KNEXT: begin
          if (cnt == '0) begin
            if (!pass2) begin
              pass2 <= 1'b1;
              cnt   <= IDX_LAST;
              st    <= ST_KR;
            end else begin
              st <= ST_KFIN;
            end
          end else begin
            st <= ST_KR;
          end
        end
        ST_KFIN: begin
          idx <= IDX_USED;
          st  <= ST_IDLE;
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (st == ST_DOUT && out_free) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st == ST_DOUT && out_free) begin
      out_word <= temper(s_rdata);
    end
  end

endmodule

`default_nettype wire

@@ sv/mersenne_twister_generator.sv @@
// MT19937 pseudo-random generator with a 624-word state store
// Requests enter through push/full with op, key_word and key_last. Op 0
// draws a number, op 1 reseeds from the seed register, op 2 collects a key
// word (key_last starts the array initialization), op 3 is dropped.
// Results leave through empty/pop: random_value holds the oldest result
// while empty is low. The seed register is written with cfg_we/cfg_wdata.
// A four-entry request queue sits between intake and the engine, so new
// requests are taken while a result waits to be popped.
// The state memory has a single read port, so the engine works word by
// word: a draw from a fresh store reads one word and tempers it; a draw
// that needs a twist first rewrites all 624 words, reading the next word
// and the tap word of each; a reseed writes the 624 words in order; key
// initialization is a reseed plus two mixing passes over 1247 words.
// Reset empties the queue and the result register, sets the seed register
// to 5489 and marks the store as never seeded; the first draw seeds it.
// A stalled receiver holds one result; the engine then waits and the
// queue fills until full rises.
`default_nettype none

module mersenne_twister_generator #(
  parameter int KEY_MAX = mt_pkg::KEY_MAX_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  op,
  input  wire logic [31:0] key_word,
  input  wire logic        key_last,
  output logic             empty,
  input  wire logic        pop,
  output logic [31:0]      random_value,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata
);

  import mt_pkg::*;

  logic [31:0] seed_value;
  logic        cmd_valid;
  logic        cmd_pop;
  cmd_t        cmd;

  // seed register
  always_ff @(posedge clk) begin
    if (rst) begin
      seed_value <= SEED_DEFAULT;
    end else if (cfg_we) begin
      seed_value <= cfg_wdata;
    end
  end

  mt_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .op(op),
    .key_word(key_word), .key_last(key_last),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop)
  );

  mt_back #(.KEY_MAX(KEY_MAX)) u_back (
    .clk(clk), .rst(rst), .seed_value(seed_value),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop),
    .empty(empty), .pop(pop), .random_value(random_value)
  );

  // engine only takes requests that are queued
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> cmd_valid)
    else $error("engine took a request from an empty queue");

  // unused codes never reach the engine
  a_no_unused: assert property (@(posedge clk) disable iff (rst)
    cmd_valid |-> (cmd.op != OP_NONE))
    else $error("unused request code queued");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty)
    else $error("result pending after reset");

endmodule

`default_nettype wire
